// ===== hw/rtl/bms_pkg.sv =====
// Shared types, request codes, mode encodings and vector offsets of the banked register mode switch.
`timescale 1ns / 1ps

package bms_pkg;

  // Request codes.
  localparam logic [2:0] REQ_WRITE  = 3'd0;
  localparam logic [2:0] REQ_READ   = 3'd1;
  localparam logic [2:0] REQ_SWITCH = 3'd2;
  localparam logic [2:0] REQ_EXC    = 3'd3;
  localparam logic [2:0] REQ_IRQ    = 3'd4;
  localparam logic [2:0] REQ_WAIT   = 3'd5;

  // Register indexes above the visible registers.
  localparam logic [4:0] IDX_CPSR = 5'd16;
  localparam logic [4:0] IDX_SPSR = 5'd17;

  // Processor mode encodings.
  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  // Exception vector offsets.
  localparam logic [4:0] VEC_RESET    = 5'h00;
  localparam logic [4:0] VEC_UNDEF    = 5'h04;
  localparam logic [4:0] VEC_SWI      = 5'h08;
  localparam logic [4:0] VEC_PABORT   = 5'h0C;
  localparam logic [4:0] VEC_DABORT   = 5'h10;
  localparam logic [4:0] VEC_RESERVED = 5'h14;
  localparam logic [4:0] VEC_IRQ      = 5'h18;
  localparam logic [4:0] VEC_FIQ      = 5'h1C;

  localparam logic [31:0] HIGH_BASE = 32'hFFFF_0000;
  localparam int unsigned BIT_T = 5;
  localparam int unsigned BIT_I = 7;

  // One request word.
  typedef struct packed {
    logic [2:0]  req_type;
    logic [4:0]  reg_index;
    logic [31:0] write_value;
    logic [4:0]  new_mode;
    logic [4:0]  vector_offset;
    logic [31:0] return_address;
  } req_t;

  // One response word.
  typedef struct packed {
    logic [31:0] read_data;
    logic [4:0]  previous_mode;
    logic [31:0] next_pc;
    logic        halted;
    logic        waiting_irq;
  } rsp_t;

  // Bank slot of a privileged non-FIQ mode.
  typedef struct packed {
    logic       ok;
    logic [1:0] slot;
  } slot_t;

  function automatic slot_t slot_of(logic [4:0] mode);
    slot_t s;
    s.ok   = 1'b1;
    s.slot = 2'd0;
    unique case (mode)
      MODE_SVC: s.slot = 2'd0;
      MODE_ABT: s.slot = 2'd1;
      MODE_UND: s.slot = 2'd2;
      MODE_IRQ: s.slot = 2'd3;
      default:  s.ok   = 1'b0;
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/bms_req_if.sv =====
// Request channel of the banked register mode switch.
`timescale 1ns / 1ps

interface bms_req_if
  import bms_pkg::*;
();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bms_rsp_if.sv =====
// Response channel of the banked register mode switch.
`timescale 1ns / 1ps

interface bms_rsp_if
  import bms_pkg::*;
();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/banked_register_mode_switch.sv =====
// Banked register file and processor mode logic with one request and one response channel.
//
// Usage:
//   req_i carries one request word per handshake: a register write or read, a mode
//   switch, an exception entry, an IRQ entry or a wait for IRQ. rsp_o returns exactly
//   one word per request, in order. cfg_we_i/cfg_wdata_i write the high-vectors bit;
//   write it only while no request is in flight.
// Timing:
//   A request is captured in an input register, processed against the register file and
//   mode state, and written to the response register. Throughput is one word per cycle
//   while rsp_o is not stalled, set by the single combinational pass from the input
//   register to the state and response registers.
// Reset:
//   rst_ni clears the state and valid registers (not the stage data words), sets CPSR and
//   SPSR to system mode and the vector base to zero. Both stages come up empty.
// Back-pressure:
//   When rsp_o is stalled the response register holds, the input register keeps its
//   word, and req_i still accepts while the input register is empty.
`timescale 1ns / 1ps

module banked_register_mode_switch
  import bms_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  bms_req_if.sink  req_i,
  bms_rsp_if.source rsp_o
);

  // Pipeline control and data registers.
  logic        in_valid_q;
  req_t        in_q;
  logic        out_valid_q;
  rsp_t        out_q;
  logic        advance;
  logic        step;

  // Architectural state.
  logic [31:0] vis_q [16];
  logic [31:0] vis_d [16];
  logic [31:0] bnk_q [17];
  logic [31:0] bnk_d [17];
  logic [31:0] bss_q [5];
  logic [31:0] bss_d [5];
  logic [31:0] cpsr_q, cpsr_d;
  logic [31:0] spsr_q, spsr_d;
  logic        wait_q, wait_d;
  logic        hv_q;
  rsp_t        rsp_d;

  // Handshake: the processing stage moves when the response register can take a word.
  assign advance     = !out_valid_q || rsp_o.ready;
  assign step        = in_valid_q && advance;
  assign req_i.ready = !in_valid_q || advance;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // Single-pass request processing.
  always_comb begin
    logic [4:0]  old_mode;
    logic [4:0]  target;
    logic        do_switch;
    logic        entry;
    logic [31:0] base;
    logic [31:0] tmp;
    slot_t       so;
    slot_t       st;
    logic [4:0]  bi;

    vis_d    = vis_q;
    bnk_d    = bnk_q;
    bss_d    = bss_q;
    cpsr_d   = cpsr_q;
    spsr_d   = spsr_q;
    wait_d   = wait_q;
    rsp_d    = '0;
    tmp      = '0;
    so       = '0;
    st       = '0;
    bi       = '0;
    old_mode = cpsr_q[4:0];
    base     = hv_q ? HIGH_BASE : 32'd0;
    rsp_d.previous_mode = old_mode;

    // Target mode of a switch or an entry.
    target = MODE_USR;
    case (in_q.req_type)
      REQ_SWITCH: target = in_q.new_mode;
      REQ_IRQ:    target = MODE_IRQ;
      default: begin
        case (in_q.vector_offset)
          VEC_RESET, VEC_SWI:     target = MODE_SVC;
          VEC_UNDEF:              target = MODE_UND;
          VEC_PABORT, VEC_DABORT: target = MODE_ABT;
          VEC_IRQ:                target = MODE_IRQ;
          VEC_FIQ:                target = MODE_FIQ;
          default:                target = MODE_USR;
        endcase
      end
    endcase
    do_switch = (in_q.req_type == REQ_SWITCH) || (in_q.req_type == REQ_EXC) ||
                (in_q.req_type == REQ_IRQ);
    entry     = (in_q.req_type == REQ_EXC) || (in_q.req_type == REQ_IRQ);

    if (do_switch) begin
      // Save the old mode's registers into its bank.
      so = slot_of(old_mode);
      if (old_mode == MODE_USR || old_mode == MODE_SYS) begin
        bnk_d[0] = vis_d[13];
        bnk_d[1] = vis_d[14];
      end else if (old_mode == MODE_FIQ) begin
        for (int i = 0; i < 5; i++) begin
          tmp               = vis_d[4'(8 + i)];
          vis_d[4'(8 + i)]  = bnk_d[5'(10 + i)];
          bnk_d[5'(10 + i)] = tmp;
        end
        bnk_d[15] = vis_d[13];
        bnk_d[16] = vis_d[14];
        bss_d[4]  = spsr_d;
      end else if (so.ok) begin
        bi              = {2'b00, so.slot, 1'b0} + 5'd2;
        bnk_d[bi]       = vis_d[13];
        bnk_d[bi + 5'd1] = vis_d[14];
        bss_d[{1'b0, so.slot}] = spsr_d;
      end

      // Load the new mode's bank.
      st = slot_of(target);
      if (target == MODE_USR || target == MODE_SYS) begin
        vis_d[13] = bnk_d[0];
        vis_d[14] = bnk_d[1];
      end else if (target == MODE_FIQ) begin
        for (int i = 0; i < 5; i++) begin
          tmp               = vis_d[4'(8 + i)];
          vis_d[4'(8 + i)]  = bnk_d[5'(10 + i)];
          bnk_d[5'(10 + i)] = tmp;
        end
        vis_d[13] = bnk_d[15];
        vis_d[14] = bnk_d[16];
        spsr_d    = bss_d[4];
      end else if (st.ok) begin
        bi        = {2'b00, st.slot, 1'b0} + 5'd2;
        vis_d[13] = bnk_d[bi];
        vis_d[14] = bnk_d[bi + 5'd1];
        spsr_d    = bss_d[{1'b0, st.slot}];
      end
      cpsr_d[4:0] = target;
    end

    // Exception and IRQ entry bookkeeping.
    if (entry) begin
      spsr_d        = cpsr_q;
      cpsr_d[BIT_T] = 1'b0;
      cpsr_d[BIT_I] = 1'b1;
      if (in_q.req_type == REQ_EXC) begin
        vis_d[14]     = in_q.return_address;
        rsp_d.next_pc = base + {27'd0, in_q.vector_offset};
        vis_d[15]     = rsp_d.next_pc;
        rsp_d.halted  = (in_q.vector_offset == VEC_RESERVED);
      end else begin
        vis_d[14]     = in_q.return_address + 32'd4;
        rsp_d.next_pc = base + {27'd0, VEC_IRQ};
        wait_d        = 1'b0;
      end
    end

    // Register access and wait requests.
    case (in_q.req_type)
      REQ_WRITE: begin
        if (!in_q.reg_index[4]) begin
          vis_d[in_q.reg_index[3:0]] = in_q.write_value;
        end else if (in_q.reg_index == IDX_CPSR) begin
          cpsr_d = in_q.write_value;
        end else if (in_q.reg_index == IDX_SPSR) begin
          spsr_d = in_q.write_value;
        end
      end
      REQ_READ: begin
        if (!in_q.reg_index[4]) begin
          rsp_d.read_data = vis_q[in_q.reg_index[3:0]];
        end else if (in_q.reg_index == IDX_CPSR) begin
          rsp_d.read_data = cpsr_q;
        end else if (in_q.reg_index == IDX_SPSR) begin
          rsp_d.read_data = spsr_q;
        end
      end
      REQ_WAIT: wait_d = 1'b1;
      default: ;
    endcase

    rsp_d.waiting_irq = wait_d;
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_q <= req_i.data;
    end
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= rsp_d;
    end
  end

  // Architectural state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) vis_q[i] <= '0;
      for (int i = 0; i < 17; i++) bnk_q[i] <= '0;
      for (int i = 0; i < 5; i++) bss_q[i] <= '0;
      cpsr_q <= {27'd0, MODE_SYS};
      spsr_q <= {27'd0, MODE_SYS};
      wait_q <= 1'b0;
      hv_q   <= 1'b0;
    end else begin
      if (step) begin
        vis_q  <= vis_d;
        bnk_q  <= bnk_d;
        bss_q  <= bss_d;
        cpsr_q <= cpsr_d;
        spsr_q <= spsr_d;
        wait_q <= wait_d;
      end
      if (cfg_we_i) begin
        hv_q <= cfg_wdata_i;
      end
    end
  end

`ifndef SYNTH
  // A halted response always carries the reserved vector.
  a_halt_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.halted |-> out_q.next_pc[4:0] == VEC_RESERVED)
    else $error("halted response without reserved vector");

  // Only a read produces read data; reads never produce a vector.
  a_read_no_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.read_data != 32'd0 |-> out_q.next_pc == 32'd0 && !out_q.halted)
    else $error("read data together with a vector");

  // Entry leaves interrupts masked and ARM state selected.
  a_entry_masks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (in_q.req_type == REQ_EXC || in_q.req_type == REQ_IRQ)
      |=> cpsr_q[BIT_I] && !cpsr_q[BIT_T])
    else $error("entry did not set I or clear T");

  // A word held back by a stalled output stays in the input register.
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("input stage lost a word under stall");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the banked register file and processor mode switch.
`timescale 1ns / 1ps

module testbench
  import bms_pkg::*;
();

  // Codes that the package leaves out: an unused request type and out-of-range selectors.
  localparam logic [2:0] REQ_NONE  = 3'd7;
  localparam logic [4:0] IDX_NONE  = 5'd31;
  localparam logic [4:0] MODE_NONE = 5'h00;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  bms_req_if req_bus ();
  bms_rsp_if rsp_bus ();

  banked_register_mode_switch uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the register file, mode state and vector base setting.
  logic [31:0] gpr [16]      = '{default: '0};
  logic [31:0] bank_gpr [17] = '{default: '0};
  logic [31:0] bank_spsr [5] = '{default: '0};
  logic [31:0] cpsr_q        = {27'b0, MODE_SYS};
  logic [31:0] spsr_q        = {27'b0, MODE_SYS};
  logic        wfi_q         = 1'b0;
  logic        vec_high      = 1'b0;

  rsp_t pending_rsp [$];
  rsp_t want_rsp;
  int   err_count   = 0;
  int   useful_sent = 0;

  // Traffic shaping shared by the sender, the receiver and the tests.
  int gap_max    = 0;
  int stall_pct  = 0;
  int burst_left = 0;
  int hold_left  = 0;

  // R13/R14/SPSR bank slot of a privileged mode other than FIQ, or -1.
  function automatic int bank_slot(input logic [4:0] m);
    case (m)
      MODE_SVC: return 0;
      MODE_ABT: return 1;
      MODE_UND: return 2;
      MODE_IRQ: return 3;
      default:  return -1;
    endcase
  endfunction

  function automatic void swap_fiq_bank();
    logic [31:0] t;
    for (int i = 0; i < 5; i++) begin
      t = gpr[8 + i];
      gpr[8 + i] = bank_gpr[10 + i];
      bank_gpr[10 + i] = t;
    end
  endfunction

  // Save the old mode's bank, load the new one and set the mode field; gives the old mode.
  function automatic logic [4:0] enter_mode(input logic [4:0] target);
    logic [4:0] old;
    int s;
    old = cpsr_q[4:0];
    if (old == MODE_USR || old == MODE_SYS) begin
      bank_gpr[0] = gpr[13];
      bank_gpr[1] = gpr[14];
    end else if (old == MODE_FIQ) begin
      swap_fiq_bank();
      bank_gpr[15] = gpr[13];
      bank_gpr[16] = gpr[14];
      bank_spsr[4] = spsr_q;
    end else begin
      s = bank_slot(old);
      if (s >= 0) begin
        bank_gpr[2 + 2 * s] = gpr[13];
        bank_gpr[3 + 2 * s] = gpr[14];
        bank_spsr[s] = spsr_q;
      end
    end
    if (target == MODE_USR || target == MODE_SYS) begin
      gpr[13] = bank_gpr[0];
      gpr[14] = bank_gpr[1];
    end else if (target == MODE_FIQ) begin
      swap_fiq_bank();
      gpr[13] = bank_gpr[15];
      gpr[14] = bank_gpr[16];
      spsr_q = bank_spsr[4];
    end else begin
      s = bank_slot(target);
      if (s >= 0) begin
        gpr[13] = bank_gpr[2 + 2 * s];
        gpr[14] = bank_gpr[3 + 2 * s];
        spsr_q = bank_spsr[s];
      end
    end
    cpsr_q[4:0] = target;
    return old;
  endfunction

  // Serve one request word against the shadow state and give the response it must produce.
  function automatic rsp_t apply_request(input req_t r);
    rsp_t o;
    logic [31:0] old_cpsr;
    logic [31:0] base;
    logic [4:0] target;
    o = '0;
    o.previous_mode = cpsr_q[4:0];
    old_cpsr = cpsr_q;
    base = vec_high ? HIGH_BASE : 32'h0;
    case (r.req_type)
      REQ_WRITE: begin
        if (r.reg_index < IDX_CPSR) gpr[r.reg_index[3:0]] = r.write_value;
        else if (r.reg_index == IDX_CPSR) cpsr_q = r.write_value;
        else if (r.reg_index == IDX_SPSR) spsr_q = r.write_value;
      end
      REQ_READ: begin
        if (r.reg_index < IDX_CPSR) o.read_data = gpr[r.reg_index[3:0]];
        else if (r.reg_index == IDX_CPSR) o.read_data = cpsr_q;
        else if (r.reg_index == IDX_SPSR) o.read_data = spsr_q;
      end
      REQ_SWITCH: o.previous_mode = enter_mode(r.new_mode);
      REQ_EXC: begin
        // Offsets off the table land in user mode; the reserved one also halts.
        target = MODE_USR;
        case (r.vector_offset)
          VEC_RESET:    target = MODE_SVC;
          VEC_UNDEF:    target = MODE_UND;
          VEC_SWI:      target = MODE_SVC;
          VEC_PABORT:   target = MODE_ABT;
          VEC_DABORT:   target = MODE_ABT;
          VEC_RESERVED: o.halted = 1'b1;
          VEC_IRQ:      target = MODE_IRQ;
          VEC_FIQ:      target = MODE_FIQ;
          default: ;
        endcase
        o.previous_mode = enter_mode(target);
        gpr[14] = r.return_address;
        spsr_q = old_cpsr;
        cpsr_q[BIT_T] = 1'b0;
        cpsr_q[BIT_I] = 1'b1;
        o.next_pc = base + {27'b0, r.vector_offset};
        gpr[15] = o.next_pc;
      end
      REQ_IRQ: begin
        o.previous_mode = enter_mode(MODE_IRQ);
        gpr[14] = r.return_address + 32'd4;
        spsr_q = old_cpsr;
        cpsr_q[BIT_T] = 1'b0;
        cpsr_q[BIT_I] = 1'b1;
        o.next_pc = base + {27'b0, VEC_IRQ};
        wfi_q = 1'b0;
      end
      REQ_WAIT: wfi_q = 1'b1;
      default: ;
    endcase
    o.waiting_irq = wfi_q;
    return o;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < 50) $display("ERROR at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  // Offer one request word in bursts with random gaps and wait until it is taken.
  // Returns at the accepting edge without touching valid.
  task automatic send_req(input req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_bus.valid <= 1'b1;
    req_bus.data  <= r;
    do @(posedge clk_i); while (!req_bus.ready);
    pending_rsp.push_back(apply_request(r));
    if (r.req_type <= REQ_WAIT) useful_sent++;
  endtask

  task automatic send_op(input logic [2:0] kind, input logic [4:0] idx,
                         input logic [31:0] wval, input logic [4:0] mode,
                         input logic [4:0] voff, input logic [31:0] raddr);
    req_t r;
    r.req_type       = kind;
    r.reg_index      = idx;
    r.write_value    = wval;
    r.new_mode       = mode;
    r.vector_offset  = voff;
    r.return_address = raddr;
    send_req(r);
  endtask

  // Stop offering, wait for every outstanding response and let the pipeline settle.
  task automatic drain_requests();
    req_bus.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_high_vectors(input logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    vec_high     = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Fully random request word, every field over its whole width.
  function automatic req_t any_req();
    req_t r;
    logic [31:0] a;
    a = $urandom();
    r.req_type       = a[2:0];
    r.reg_index      = a[7:3];
    r.new_mode       = a[12:8];
    r.vector_offset  = a[17:13];
    r.write_value    = $urandom();
    r.return_address = $urandom();
    return r;
  endfunction

  // Mostly architectural modes, now and then any encoding.
  function automatic logic [4:0] pick_mode();
    logic [31:0] a;
    case ($urandom_range(0, 7))
      0: return MODE_USR;
      1: return MODE_FIQ;
      2: return MODE_IRQ;
      3: return MODE_SVC;
      4: return MODE_ABT;
      5: return MODE_UND;
      6: return MODE_SYS;
      default: begin
        a = $urandom();
        return a[4:0];
      end
    endcase
  endfunction

  // Weighted toward the banked registers R8-R14 and the SPSR.
  function automatic logic [4:0] pick_index();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 5'($urandom_range(8, 14));
    if (p < 75) return 5'($urandom_range(0, 15));
    if (p < 85) return IDX_SPSR;
    if (p < 93) return IDX_CPSR;
    return 5'($urandom_range(18, 31));
  endfunction

  // One short program fragment: bank traffic, an exception round trip, a wait and IRQ,
  // or a random word.
  task automatic random_sequence();
    req_t r;
    int kind;
    logic [31:0] saved;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      r = any_req();
      r.req_type = REQ_SWITCH;
      r.new_mode = pick_mode();
      send_req(r);
      repeat ($urandom_range(1, 4)) begin
        r = any_req();
        r.req_type  = REQ_WRITE;
        r.reg_index = pick_index();
        if (r.reg_index == IDX_CPSR) r.write_value[4:0] = pick_mode();
        send_req(r);
      end
      repeat ($urandom_range(1, 3)) begin
        r = any_req();
        r.req_type  = REQ_READ;
        r.reg_index = pick_index();
        send_req(r);
      end
    end else if (kind < 75) begin
      r = any_req();
      r.req_type = REQ_EXC;
      if ($urandom_range(0, 9) != 0) r.vector_offset[1:0] = 2'b00;
      send_req(r);
      r = any_req();
      r.req_type  = REQ_READ;
      r.reg_index = pick_index();
      send_req(r);
      // Return to the interrupted mode, restoring the saved status word.
      saved = spsr_q;
      r = any_req();
      r.req_type = REQ_SWITCH;
      r.new_mode = saved[4:0];
      send_req(r);
      r = any_req();
      r.req_type    = REQ_WRITE;
      r.reg_index   = IDX_CPSR;
      r.write_value = saved;
      send_req(r);
    end else if (kind < 85) begin
      r = any_req();
      r.req_type = REQ_WAIT;
      send_req(r);
      r = any_req();
      r.req_type = REQ_IRQ;
      send_req(r);
      r = any_req();
      r.req_type  = REQ_READ;
      r.reg_index = ($urandom_range(0, 1) != 0) ? IDX_SPSR : 5'd14;
      send_req(r);
    end else begin
      send_req(any_req());
    end
  endtask

  // Register reads and writes in system mode, including the status words and bad indexes.
  task automatic test_register_access();
    gap_max   = 3;
    stall_pct = 20;
    send_op(REQ_READ, IDX_CPSR, '0, MODE_NONE, VEC_RESET, '0);
    send_op(REQ_READ, IDX_SPSR, '0, MODE_NONE, VEC_RESET, '0);
    send_op(REQ_WRITE, 5'd0, 32'hFFFF_FFFF, MODE_NONE, VEC_RESET, '0);
    send_op(REQ_READ, 5'd0, '0, MODE_NONE, VEC_RESET, '0);
    send_op(REQ_WRITE, IDX_NONE, 32'hFFFF_FFFF, MODE_NONE, VEC_RESET, '0);
    send_op(REQ_READ, IDX_NONE, 32'hFFFF_FFFF, 5'h1F, 5'h1F, 32'hFFFF_FFFF);
    // A whole-word status write keeps system mode but sets every flag bit.
    send_op(REQ_WRITE, IDX_CPSR, 32'hFFFF_FFFF, MODE_NONE, VEC_RESET, '0);
    send_op(REQ_READ, IDX_CPSR, '0, MODE_NONE, VEC_RESET, '0);
    send_op(REQ_NONE, IDX_NONE, 32'hFFFF_FFFF, 5'h1F, 5'h1F, 32'hFFFF_FFFF);
    drain_requests();
  endtask

  // FIQ banking, a switch into the same mode and a switch through an unknown encoding.
  task automatic test_mode_banking();
    gap_max   = 0;
    stall_pct = 0;
    send_op(REQ_SWITCH, 5'd0, '0, MODE_FIQ, VEC_RESET, '0);
    send_op(REQ_WRITE, 5'd8, 32'hA5A5_5A5A, MODE_NONE, VEC_RESET, '0);
    send_op(REQ_WRITE, IDX_SPSR, 32'h1234_5611, MODE_NONE, VEC_RESET, '0);
    send_op(REQ_SWITCH, 5'd0, '0, MODE_FIQ, VEC_RESET, '0);
    send_op(REQ_READ, 5'd8, '0, MODE_NONE, VEC_RESET, '0);
    send_op(REQ_SWITCH, 5'd0, '0, MODE_NONE, VEC_RESET, '0);
    send_op(REQ_SWITCH, 5'd0, '0, MODE_SVC, VEC_RESET, '0);
    send_op(REQ_READ, 5'd8, '0, MODE_NONE, VEC_RESET, '0);
    drain_requests();
  endtask

  // Every vector, an offset off the table, and an IRQ taken out of a wait.
  task automatic test_exception_entry();
    gap_max   = 2;
    stall_pct = 40;
    send_op(REQ_EXC, 5'd0, '0, MODE_NONE, VEC_RESET, 32'h0000_0000);
    send_op(REQ_EXC, 5'd0, '0, MODE_NONE, VEC_UNDEF, 32'hFFFF_FFFF);
    send_op(REQ_EXC, 5'd0, '0, MODE_NONE, VEC_SWI, $urandom());
    send_op(REQ_EXC, 5'd0, '0, MODE_NONE, VEC_PABORT, $urandom());
    send_op(REQ_EXC, 5'd0, '0, MODE_NONE, VEC_DABORT, $urandom());
    send_op(REQ_EXC, 5'd0, '0, MODE_NONE, VEC_RESERVED, $urandom());
    send_op(REQ_EXC, 5'd0, '0, MODE_NONE, VEC_IRQ, $urandom());
    send_op(REQ_EXC, 5'd0, '0, MODE_NONE, VEC_FIQ, $urandom());
    // Not a multiple of four and beyond the last vector.
    send_op(REQ_EXC, 5'd0, '0, MODE_NONE, 5'h1F, $urandom());
    send_op(REQ_WAIT, 5'd0, '0, MODE_NONE, VEC_RESET, '0);
    // The link value wraps past the top of the address space.
    send_op(REQ_IRQ, 5'd0, '0, MODE_NONE, VEC_RESET, 32'hFFFF_FFFF);
    drain_requests();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering words.
  task automatic test_backpressure();
    int start;
    gap_max   = 0;
    stall_pct = 0;
    hold_left = 80;
    start = useful_sent;
    while (useful_sent - start < 40) random_sequence();
    drain_requests();
  endtask

  task automatic test_random_traffic(input logic hv, input int count, input int gaps,
                                     input int stalls);
    int start;
    set_high_vectors(hv);
    gap_max   = gaps;
    stall_pct = stalls;
    start = useful_sent;
    while (useful_sent - start < count) random_sequence();
    drain_requests();
  endtask

  // Receiver: a long hold when one is requested, otherwise random stalls.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Compare each accepted response word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("response word with no request outstanding");
      end else begin
        want_rsp = pending_rsp.pop_front();
        if (rsp_bus.data.read_data !== want_rsp.read_data)
          report_mismatch($sformatf("read_data %h, expected %h",
                                    rsp_bus.data.read_data, want_rsp.read_data));
        if (rsp_bus.data.previous_mode !== want_rsp.previous_mode)
          report_mismatch($sformatf("previous_mode %h, expected %h",
                                    rsp_bus.data.previous_mode, want_rsp.previous_mode));
        if (rsp_bus.data.next_pc !== want_rsp.next_pc)
          report_mismatch($sformatf("next_pc %h, expected %h",
                                    rsp_bus.data.next_pc, want_rsp.next_pc));
        if (rsp_bus.data.halted !== want_rsp.halted)
          report_mismatch($sformatf("halted %b, expected %b",
                                    rsp_bus.data.halted, want_rsp.halted));
        if (rsp_bus.data.waiting_irq !== want_rsp.waiting_irq)
          report_mismatch($sformatf("waiting_irq %b, expected %b",
                                    rsp_bus.data.waiting_irq, want_rsp.waiting_irq));
      end
    end
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.data  = '0;
    rsp_bus.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_mode_banking();
    test_exception_entry();
    test_backpressure();
    test_random_traffic(1'b1, 325, 6, 30);
    test_random_traffic(1'b0, 325, 0, 0);
    test_random_traffic(1'b1, 325, 10, 60);

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bms_pkg.sv
hw/rtl/bms_req_if.sv
hw/rtl/bms_rsp_if.sv
hw/rtl/banked_register_mode_switch.sv
verif/testbench.sv
